// File: hw/rtl/ars_pkg.sv
// Shared types, constants and helpers for the adaptive resolution scaler.
package ars_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SCALE    = 3'd0,
        CFG_MAX_SCALE    = 3'd1,
        CFG_ADJ_INTERVAL = 3'd2,
        CFG_SCALE_STEP   = 3'd3,
        CFG_TIME_BUDGET  = 3'd4
    } t_cfg_idx;

    localparam logic [8:0]  SCALE_FLOOR = 9'd64;
    localparam logic [8:0]  SCALE_FULL  = 9'd256;
    localparam logic [7:0]  STEP_FLOOR  = 8'd13;
    localparam logic [7:0]  STEP_CEIL   = 8'd128;
    localparam logic [1:0]  OVER_LIMIT  = 2'd2;
    localparam logic [2:0]  UNDER_LIMIT = 3'd6;

    localparam logic [8:0]  RST_MIN_SCALE = 9'd64;
    localparam logic [8:0]  RST_MAX_SCALE = 9'd256;
    localparam logic [15:0] RST_INTERVAL  = 16'd1;
    localparam logic [7:0]  RST_STEP      = 8'd26;
    localparam logic [15:0] RST_BUDGET    = 16'd4267;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  context_req;
        logic [31:0] frame_number;
        logic [15:0] gpu_time;
    } t_in_req;

    typedef struct packed {
        logic [8:0]  scale;
        logic [15:0] filtered_time;
    } t_out_rsp;

    // request body as carried through the queue, context index kept apart
    typedef struct packed {
        logic [31:0] frame_number;
        logic [15:0] gpu_time;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    typedef struct packed {
        logic [8:0]  scale;
        logic [15:0] filt;
        logic [1:0]  over_cnt;
        logic [2:0]  under_cnt;
        logic [31:0] last_frame;
    } t_ctx_state;

    localparam t_ctx_state CTX_RESET = '{
        scale: 9'd256, filt: 16'd0, over_cnt: 2'd0, under_cnt: 3'd0, last_frame: 32'd0
    };

    // effective configuration after clamping; budget11 is time_budget * 11
    typedef struct packed {
        logic [8:0]  lo;
        logic [8:0]  hi;
        logic [15:0] ivl;
        logic [7:0]  step;
        logic [19:0] budget11;
    } t_cfg_eff;

    function automatic logic [8:0] clamp9(logic [8:0] v, logic [8:0] lo, logic [8:0] hi);
        logic [8:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/adaptive_resolution_scaler_top.sv
// Top level of the adaptive resolution scaler: configuration registers and part wiring.
//
// Usage: each request on the input channel (i_valid / o_ready, payload i_req) is one
// frame report for one context; every request yields exactly one response on the
// output channel (o_valid / i_ready, payload o_rsp) holding that context's scale and
// filtered GPU time after the report is applied. Responses come back in request order.
// An accepted request passes through the two-entry request queue, the state table read
// and the update stage that loads the output register, in that order. Throughput is one
// request per cycle while i_ready stays high, also for back-to-back reports on the
// same context, which are served by forwarding the retiring update into the read path.
// When the receiver holds i_ready low the output register keeps its response, the
// pipeline stages fill, then the queue fills and o_ready drops after two more requests.
// Reset clears all valid flags and loads the default configuration; every context
// reads as full scale with no history until first updated, so no clearing pass is run.
// Configuration must be written through i_cfg_we / i_cfg_idx / i_cfg_data only while no
// request is in flight; the block does not enforce it. Clamped values apply via r_cfg.
module adaptive_resolution_scaler_top #(
    parameter int NUM_CONTEXTS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  ars_pkg::t_in_req                 i_req,
    output logic                             o_valid,
    input  logic                             i_ready,
    output ars_pkg::t_out_rsp                o_rsp,
    input  logic                             i_cfg_we,
    input  logic [ars_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ars_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CTX_W   = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int ENTRY_W = CTX_W + ars_pkg::ITEM_W;

    logic [8:0]        r_min_scale;
    logic [8:0]        r_max_scale;
    logic [15:0]       r_interval;
    logic [7:0]        r_step;
    logic [15:0]       r_budget;
    ars_pkg::t_cfg_eff r_cfg;
    ars_pkg::t_cfg_eff n_cfg;

    logic               w_q_ready;
    logic               w_push;
    logic [ENTRY_W-1:0] w_entry;
    logic               w_q_valid;
    logic [ENTRY_W-1:0] w_q_data;
    logic               w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_scale <= ars_pkg::RST_MIN_SCALE;
            r_max_scale <= ars_pkg::RST_MAX_SCALE;
            r_interval  <= ars_pkg::RST_INTERVAL;
            r_step      <= ars_pkg::RST_STEP;
            r_budget    <= ars_pkg::RST_BUDGET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ars_pkg::CFG_MIN_SCALE: begin
                    r_min_scale <= i_cfg_data[8:0];
                end
                ars_pkg::CFG_MAX_SCALE: begin
                    r_max_scale <= i_cfg_data[8:0];
                end
                ars_pkg::CFG_ADJ_INTERVAL: begin
                    r_interval <= i_cfg_data;
                end
                ars_pkg::CFG_SCALE_STEP: begin
                    r_step <= i_cfg_data[7:0];
                end
                ars_pkg::CFG_TIME_BUDGET: begin
                    r_budget <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_cfg.lo  = ars_pkg::clamp9(r_min_scale, ars_pkg::SCALE_FLOOR, ars_pkg::SCALE_FULL);
        n_cfg.hi  = ars_pkg::clamp9(r_max_scale, n_cfg.lo, ars_pkg::SCALE_FULL);
        n_cfg.ivl = (r_interval == 16'd0) ? 16'd1 : r_interval;
        if (r_step < ars_pkg::STEP_FLOOR) begin
            n_cfg.step = ars_pkg::STEP_FLOOR;
        end else if (r_step > ars_pkg::STEP_CEIL) begin
            n_cfg.step = ars_pkg::STEP_CEIL;
        end else begin
            n_cfg.step = r_step;
        end
        n_cfg.budget11 = ({4'd0, r_budget} << 3) + ({4'd0, r_budget} << 1) + {4'd0, r_budget};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lo       <= ars_pkg::RST_MIN_SCALE;
            r_cfg.hi       <= ars_pkg::RST_MAX_SCALE;
            r_cfg.ivl      <= ars_pkg::RST_INTERVAL;
            r_cfg.step     <= ars_pkg::RST_STEP;
            r_cfg.budget11 <= 20'd46937;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ars_front #(
        .NUM_CONTEXTS(NUM_CONTEXTS)
    ) u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (i_req),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_entry   (w_entry)
    );

    ars_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    ars_back #(
        .NUM_CONTEXTS(NUM_CONTEXTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rsp     (o_rsp)
    );

endmodule

// File: hw/rtl/ars_queue.sv
// Two-entry request queue between the front and back parts.
module ars_queue #(
    parameter int WIDTH = 50
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int CNT_W = $clog2(ars_pkg::Q_DEPTH + 1);
    localparam int PTR_W = $clog2(ars_pkg::Q_DEPTH);

    logic [WIDTH-1:0] r_mem [ars_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(ars_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(ars_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    assign o_ready = (r_count != CNT_W'(ars_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

endmodule

// File: hw/rtl/ars_front.sv
// Front part: accepts frame reports and maps the context onto a table entry.
module ars_front #(
    parameter int NUM_CONTEXTS = 4
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  ars_pkg::t_in_req  i_req,
    input  logic              i_q_ready,
    output logic              o_push,
    output logic [((NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1) + ars_pkg::ITEM_W - 1:0]
                              o_entry
);

    localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

    logic [CTX_W-1:0]  w_ctx_map [4];
    logic [CTX_W-1:0]  w_ctx;
    ars_pkg::t_item    w_item;

    // context field reduced modulo the table depth
    for (genvar v = 0; v < 4; v++) begin : g_map
        localparam int MAPPED = v % NUM_CONTEXTS;
        assign w_ctx_map[v] = CTX_W'(MAPPED);
    end

    always_comb begin
        w_ctx               = w_ctx_map[i_req.context_req];
        w_item.frame_number = i_req.frame_number;
        w_item.gpu_time     = i_req.gpu_time;
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
    assign o_entry = {w_ctx, w_item};

endmodule

// File: hw/rtl/ars_back.sv
// Back part: per-context state table, read stage, update stage and output register.
module ars_back #(
    parameter int NUM_CONTEXTS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ars_pkg::t_cfg_eff i_cfg,
    input  logic              i_q_valid,
    input  logic [((NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1) + ars_pkg::ITEM_W - 1:0]
                              i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output ars_pkg::t_out_rsp o_rsp
);

    localparam int CTX_W   = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int ENTRY_W = CTX_W + ars_pkg::ITEM_W;

    ars_pkg::t_ctx_state r_mem [NUM_CONTEXTS];
    logic [NUM_CONTEXTS-1:0] r_vld;

    logic                r_s1_v;
    logic [CTX_W-1:0]    r_s1_ctx;
    ars_pkg::t_item      r_s1_item;
    ars_pkg::t_ctx_state r_rd_data;
    logic                r_s1_fwd;
    ars_pkg::t_ctx_state r_s1_fwd_st;

    logic                r_s2_v;
    logic [CTX_W-1:0]    r_s2_ctx;
    ars_pkg::t_item      r_s2_item;
    ars_pkg::t_ctx_state r_s2_st;

    logic                r_out_v;
    ars_pkg::t_out_rsp   r_out;

    logic [CTX_W-1:0]    w_q_ctx;
    ars_pkg::t_item      w_q_item;
    logic                w_out_adv;
    logic                w_s2_free;
    logic                w_s1_adv;
    logic                w_s1_free;
    logic                w_pop;
    logic                w_hit_q;
    logic                w_hit_s1;
    ars_pkg::t_ctx_state w_s1_st;
    ars_pkg::t_ctx_state n_ctx_st;

    logic [8:0]  w_sc;
    logic [31:0] w_age;
    logic        w_pass;
    logic [15:0] w_g;
    logic [15:0] w_f;
    logic [15:0] w_up_delta;
    logic [16:0] w_dn_delta;
    logic [15:0] w_nf;
    logic [20:0] w_f10;
    logic [20:0] w_f20;
    logic [20:0] w_b11;
    logic        w_over;
    logic        w_under;
    logic [1:0]  w_oc;
    logic [2:0]  w_uc;
    logic [9:0]  w_lo_step;
    logic [9:0]  w_sc_up;
    logic [8:0]  w_sc_adj;
    logic [1:0]  w_oc_f;
    logic [2:0]  w_uc_f;

    assign w_q_ctx  = i_q_data[ENTRY_W-1 -: CTX_W];
    assign w_q_item = ars_pkg::t_item'(i_q_data[ars_pkg::ITEM_W-1:0]);

    // stage advance chain, output side first
    assign w_out_adv = r_s2_v && (!r_out_v || i_ready);
    assign w_s2_free = !r_s2_v || w_out_adv;
    assign w_s1_adv  = r_s1_v && w_s2_free;
    assign w_s1_free = !r_s1_v || w_s1_adv;
    assign w_pop     = i_q_valid && w_s1_free;
    assign o_q_pop   = w_pop;

    // an update retiring in the same cycle overrides what the table returns
    assign w_hit_q  = w_out_adv && (r_s2_ctx == w_q_ctx);
    assign w_hit_s1 = w_out_adv && (r_s2_ctx == r_s1_ctx);
    assign w_s1_st  = r_s1_fwd ? r_s1_fwd_st : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_mem[r_s2_ctx] <= n_ctx_st;
        end
        if (w_pop) begin
            r_rd_data <= r_mem[w_q_ctx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_out_adv) begin
                r_vld[r_s2_ctx] <= 1'b1;
            end
            if (w_pop) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (w_out_adv) begin
                r_s2_v <= 1'b0;
            end
            if (w_out_adv) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_s1_ctx    <= w_q_ctx;
            r_s1_item   <= w_q_item;
            r_s1_fwd    <= w_hit_q || !r_vld[w_q_ctx];
            r_s1_fwd_st <= w_hit_q ? n_ctx_st : ars_pkg::CTX_RESET;
        end
        if (w_s1_adv) begin
            r_s2_ctx  <= r_s1_ctx;
            r_s2_item <= r_s1_item;
            r_s2_st   <= w_hit_s1 ? n_ctx_st : w_s1_st;
        end
        if (w_out_adv) begin
            r_out.scale         <= n_ctx_st.scale;
            r_out.filtered_time <= n_ctx_st.filt;
        end
    end

    // state update for the request in the second stage
    always_comb begin
        w_sc  = ars_pkg::clamp9(r_s2_st.scale, i_cfg.lo, i_cfg.hi);
        w_age = r_s2_item.frame_number - r_s2_st.last_frame;
        w_pass = (w_age >= {16'd0, i_cfg.ivl});
        w_g = r_s2_item.gpu_time;
        w_f = r_s2_st.filt;
        w_up_delta = w_g - w_f;
        w_dn_delta = {1'b0, w_f} - {1'b0, w_g} + 17'd3;
        // zero history loads the sample directly; decay rounds toward minus infinity
        if (w_f == 16'd0) begin
            w_nf = w_g;
        end else if (w_g >= w_f) begin
            w_nf = w_f + (w_up_delta >> 2);
        end else begin
            w_nf = w_f - {1'b0, w_dn_delta[17-1:2]};
        end
        // f*100 vs budget*110 and budget*55, scaled down by 10
        w_f10 = ({5'd0, w_nf} << 3) + ({5'd0, w_nf} << 1);
        w_f20 = w_f10 << 1;
        w_b11 = {1'b0, i_cfg.budget11};
        w_over  = (w_f10 > w_b11);
        w_under = (w_f20 < w_b11);
        w_oc = w_over ? r_s2_st.over_cnt + 2'd1 : 2'd0;
        w_uc = (!w_over && w_under) ? r_s2_st.under_cnt + 3'd1 : 3'd0;
        w_lo_step = {1'b0, i_cfg.lo} + {2'd0, i_cfg.step};
        w_sc_up   = {1'b0, w_sc} + {2'd0, i_cfg.step};
        w_sc_adj = w_sc;
        w_oc_f   = w_oc;
        w_uc_f   = w_uc;
        if (w_oc >= ars_pkg::OVER_LIMIT) begin
            w_sc_adj = ({1'b0, w_sc} >= w_lo_step) ? w_sc - {1'b0, i_cfg.step} : i_cfg.lo;
            w_oc_f   = 2'd0;
            w_uc_f   = 3'd0;
        end else if (w_uc >= ars_pkg::UNDER_LIMIT) begin
            w_sc_adj = (w_sc_up <= {1'b0, i_cfg.hi}) ? w_sc_up[8:0] : i_cfg.hi;
            w_oc_f   = 2'd0;
            w_uc_f   = 3'd0;
        end

        n_ctx_st       = r_s2_st;
        n_ctx_st.scale = w_sc;
        if (w_pass) begin
            n_ctx_st.last_frame = r_s2_item.frame_number;
            if (w_g != 16'd0) begin
                n_ctx_st.filt      = w_nf;
                n_ctx_st.over_cnt  = w_oc_f;
                n_ctx_st.under_cnt = w_uc_f;
                n_ctx_st.scale     = w_sc_adj;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

endmodule

// File: hw/rtl/ars_checker.sv
// Port-level checks for the adaptive resolution scaler, bound to the top level.
module ars_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_ready,
    input  logic              o_valid,
    input  logic              i_ready,
    input  ars_pkg::t_out_rsp o_rsp
);

    logic [3:0] r_outstanding;

    // requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 4'(i_valid && o_ready) - 4'(o_valid && i_ready);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_outstanding != 4'd0)
        else $error("response without a pending request");

    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.scale >= ars_pkg::SCALE_FLOOR) && (o_rsp.scale <= ars_pkg::SCALE_FULL))
        else $error("scale out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid right after reset");

endmodule

bind adaptive_resolution_scaler_top ars_checker u_ars_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);
